// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL modules, included by the datapath (ppiu_dp)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPIU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PPIU_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define PPIU_ASSERT(lbl, clk, rst, prop)
`define PPIU_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/ppiu_pkg.sv =====
// Shared types, constants and the field width function of the index unpacker
`timescale 1ns / 1ps
`default_nettype none
package ppiu_pkg;

   localparam int unsigned PALETTE_W   = 13;
   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned POS_W       = 12;
   localparam int unsigned FWIDTH_W    = 4;
   localparam int unsigned MIN_FIELD_BITS = 4;
   localparam int unsigned MAX_FIELD_BITS = 12;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic cnt_full;
      logic step_last;
      logic out_free;
   } sts_type;

   // max(4, ceil log2(count)), capped at 12
   function automatic logic [FWIDTH_W-1:0] field_width(input logic [PALETTE_W-1:0] count);
      logic [PALETTE_W-1:0] cm1;
      logic [FWIDTH_W-1:0]  w;
      cm1 = count - PALETTE_W'(1);
      w   = '0;
      if (count > PALETTE_W'(1)) begin
         for (int i = 0; i < PALETTE_W; i++) begin
            if (cm1[i]) w = FWIDTH_W'(i + 1);
         end
      end
      if (w < FWIDTH_W'(MIN_FIELD_BITS)) w = FWIDTH_W'(MIN_FIELD_BITS);
      if (w > FWIDTH_W'(MAX_FIELD_BITS)) w = FWIDTH_W'(MAX_FIELD_BITS);
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ppiu_ctrl.sv =====
// Controller state machine: word acceptance and per-index stepping
`timescale 1ns / 1ps
`default_nettype none
module ppiu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ppiu_pkg::sts_type sts,
   output ppiu_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // drop the rest of the word once the section is complete
            if (sts.cnt_full) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.step_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ppiu_dp.sv =====
// Datapath: field width register, word shifter, section counter, result register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ppiu_dp #(
   parameter int unsigned SECTION_BLOCKS = 4096,
   parameter int unsigned WORD_BITS      = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ppiu_pkg::PALETTE_W-1:0]     csr_wdata,
   input  wire logic [63:0]                        req_packed_word,
   input  wire logic                               req_section_start,
   input  wire ppiu_pkg::cmd_type                  cmd,
   output ppiu_pkg::sts_type                       sts,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ppiu_pkg::INDEX_W-1:0]            rsp_palette_index,
   output logic [ppiu_pkg::POS_W-1:0]              rsp_block_position,
   output logic                                    rsp_word_last,
   output logic                                    rsp_section_full
);

   localparam int unsigned CW = $clog2(SECTION_BLOCKS + 1);
   localparam int unsigned BL = $clog2(WORD_BITS + 1);
   localparam int unsigned FW = ppiu_pkg::FWIDTH_W;
   localparam int unsigned IW = ppiu_pkg::INDEX_W;
   localparam int unsigned PW = ppiu_pkg::POS_W;

   logic [FW-1:0]        width_ff, width_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [BL-1:0]        bits_left_ff, bits_left_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        index_ff, index_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 last_ff, last_in;
   logic                 full_ff, full_in;

   logic [CW-1:0]        count_next;
   logic                 full_next;
   logic                 step_last;
   logic [IW-1:0]        idx_mask;
   logic [CW+PW-1:0]     count_ext;

   assign count_next = count_ff + CW'(1);
   assign full_next  = (count_next == CW'(SECTION_BLOCKS));
   // last field of the word when fewer than two widths remain, or when this step fills the section
   assign step_last  = (bits_left_ff < BL'({width_ff, 1'b0})) || full_next;
   assign idx_mask   = ~({IW{1'b1}} << width_ff);
   assign count_ext  = {{PW{1'b0}}, count_ff};

   assign sts.cnt_full  = (count_ff >= CW'(SECTION_BLOCKS));
   assign sts.step_last = step_last;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      width_in     = width_ff;
      word_in      = word_ff;
      bits_left_in = bits_left_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      index_in     = index_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      full_in      = full_ff;

      if (csr_we) width_in = ppiu_pkg::field_width(csr_wdata);

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (cmd.load) begin
         word_in      = req_packed_word[WORD_BITS-1:0];
         bits_left_in = BL'(WORD_BITS);
         if (req_section_start) count_in = '0;
      end else if (cmd.step) begin
         index_in     = word_ff[IW-1:0] & idx_mask;
         pos_in       = count_ext[PW-1:0];
         last_in      = step_last;
         full_in      = full_next;
         rsp_valid_in = 1'b1;
         word_in      = word_ff >> width_ff;
         bits_left_in = bits_left_ff - BL'(width_ff);
         count_in     = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FW'(ppiu_pkg::MIN_FIELD_BITS);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bits_left_ff <= bits_left_in;
      index_ff     <= index_in;
      pos_ff       <= pos_in;
      last_ff      <= last_in;
      full_ff      <= full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_palette_index  = index_ff;
   assign rsp_block_position = pos_ff;
   assign rsp_word_last      = last_ff;
   assign rsp_section_full   = full_ff;

   `PPIU_NEVER(a_step_when_full, clock, reset, cmd.step && sts.cnt_full)
   `PPIU_NEVER(a_step_into_held, clock, reset, cmd.step && rsp_valid_ff && !rsp_ready)
   `PPIU_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(SECTION_BLOCKS))
   `PPIU_ASSERT(a_room_for_next, clock, reset, cmd.step && !step_last |=> bits_left_ff >= BL'(width_ff))
   `PPIU_ASSERT(a_full_is_last, clock, reset, rsp_valid_ff && full_ff |-> last_ff)

endmodule
`default_nettype wire

// ===== rtl/packed_palette_index_unpacker.sv =====
// Top level of the packed palette index unpacker
//
//  channel   ports                              direction  handshake
//  request   req_packed_word, req_section_start in         req_valid / req_ready
//  response  rsp_palette_index .. section_full  out        rsp_valid / rsp_ready
//  csr       csr_wdata (palette count)          in         csr_we, no wait
//
// A word is accepted in ST_IDLE; the single-step shifter then emits one index per cycle
// while the response side is free, floor(WORD_BITS / W) per word, fewer if the section
// fills. A word arriving on a complete section is taken and dropped with no transfer.
// A stalled response holds the next index in the shifter; the result register
// decouples the request side, so a new word is taken while the last index waits.
// Synchronous reset clears the section count; state goes idle, field width to 4 bits.
`timescale 1ns / 1ps
`default_nettype none
module packed_palette_index_unpacker #(
   parameter int unsigned SECTION_BLOCKS = 4096,
   parameter int unsigned WORD_BITS      = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [ppiu_pkg::PALETTE_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [63:0]                    req_packed_word,
   input  wire logic                           req_section_start,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ppiu_pkg::INDEX_W-1:0]        rsp_palette_index,
   output logic [ppiu_pkg::POS_W-1:0]          rsp_block_position,
   output logic                                rsp_word_last,
   output logic                                rsp_section_full
);

   ppiu_pkg::cmd_type cmd;
   ppiu_pkg::sts_type sts;

   ppiu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppiu_dp #(
      .SECTION_BLOCKS (SECTION_BLOCKS),
      .WORD_BITS      (WORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_packed_word    (req_packed_word),
      .req_section_start  (req_section_start),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_palette_index  (rsp_palette_index),
      .rsp_block_position (rsp_block_position),
      .rsp_word_last      (rsp_word_last),
      .rsp_section_full   (rsp_section_full)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the packed palette index unpacker
`timescale 1ns / 1ps
module testbench;

   localparam int unsigned INDEX_W        = ppiu_pkg::INDEX_W;
   localparam int unsigned POS_W          = ppiu_pkg::POS_W;
   localparam int unsigned PALETTE_W      = ppiu_pkg::PALETTE_W;
   localparam int unsigned MIN_FIELD_BITS = ppiu_pkg::MIN_FIELD_BITS;
   localparam int unsigned MAX_FIELD_BITS = ppiu_pkg::MAX_FIELD_BITS;

   localparam int unsigned SECTION_SIZE = 4096;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DIR_ROWS     = 20;
   localparam int unsigned LONG_WORDS   = 346;
   localparam int unsigned SHORT_PHASES = 8;
   localparam int unsigned SHORT_WORDS  = 10;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic [POS_W-1:0]   pos;
      logic               last;
      logic               full;
   } index_rec_type;

   typedef struct packed {
      logic                 set_cfg;
      logic [PALETTE_W-1:0] cfg;
      logic [63:0]          word;
      logic                 start;
      logic                 typed;
      logic [4:0]           n;
      logic [INDEX_W-1:0]   first_idx;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [PALETTE_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [63:0]          req_packed_word = '0;
   logic                 req_section_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [INDEX_W-1:0]   rsp_palette_index;
   logic [POS_W-1:0]     rsp_block_position;
   logic                 rsp_word_last;
   logic                 rsp_section_full;

   index_rec_type        index_q [$];
   index_rec_type        exp_rec;
   logic [PALETTE_W-1:0] palette_cfg;
   int unsigned          sect_fill;
   int unsigned          mismatches = 0;
   int unsigned          words_sent = 0;
   int unsigned          cycle_count = 0;
   int unsigned          hold_id = 0;
   int unsigned          hold_ack = 0;
   int unsigned          hold_left = 0;
   idle_mode_type        idle_mode = IDLE_NONE;
   dir_row_type          dir_rows [DIR_ROWS];

   packed_palette_index_unpacker u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_packed_word    (req_packed_word),
      .req_section_start  (req_section_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_palette_index  (rsp_palette_index),
      .rsp_block_position (rsp_block_position),
      .rsp_word_last      (rsp_word_last),
      .rsp_section_full   (rsp_section_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                  input logic [63:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
   endtask

   // Receiver: a requested long hold-off takes priority over the random stalls
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_id != hold_ack) begin
         hold_ack  <= hold_id;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_ready <= ($urandom_range(99, 0) >= 75);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_ready <= ($urandom_range(99, 0) >= 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (index_q.size() == 0) begin
            report_mismatch("transfer with nothing expected", '0, 64'(rsp_palette_index));
         end else begin
            exp_rec = index_q.pop_front();
            if (rsp_palette_index !== exp_rec.idx)
               report_mismatch("palette_index", 64'(exp_rec.idx), 64'(rsp_palette_index));
            if (rsp_block_position !== exp_rec.pos)
               report_mismatch("block_position", 64'(exp_rec.pos), 64'(rsp_block_position));
            if (rsp_word_last !== exp_rec.last)
               report_mismatch("word_last", 64'(exp_rec.last), 64'(rsp_word_last));
            if (rsp_section_full !== exp_rec.full)
               report_mismatch("section_full", 64'(exp_rec.full), 64'(rsp_section_full));
         end
      end
   end

   // Offer one word, then unpack it into the expected index queue once it is taken
   task automatic offer_word(input logic [63:0] word, input logic start,
                             output int unsigned n, output logic [INDEX_W-1:0] first_idx);
      int unsigned gap;
      int unsigned pct;
      int unsigned w;
      int unsigned per_word;
      logic [63:0] rest;
      index_rec_type rec;
      gap = 0;
      pct = (idle_mode == IDLE_SENDER) ? 75 : (idle_mode == IDLE_BOTH) ? 15 : 0;
      while (gap < 30 && $urandom_range(99, 0) < pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_packed_word   <= word;
      req_section_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      idle_mode <= idle_mode_type'((words_sent / 40) % 4);

      w = 0;
      while ((32'd1 << w) < palette_cfg) w++;
      if (w < MIN_FIELD_BITS) w = MIN_FIELD_BITS;
      if (w > MAX_FIELD_BITS) w = MAX_FIELD_BITS;
      per_word  = 64 / w;
      rest      = word;
      n         = 0;
      first_idx = '0;
      if (start) sect_fill = 0;
      for (int unsigned k = 0; k < per_word; k++) begin
         // a full section swallows the rest of the word
         if (sect_fill >= SECTION_SIZE) break;
         rec.idx = INDEX_W'(rest & ((64'd1 << w) - 64'd1));
         rec.pos = POS_W'(sect_fill);
         rest    = rest >> w;
         sect_fill++;
         rec.full = (sect_fill >= SECTION_SIZE);
         rec.last = (k + 1 == per_word) || rec.full;
         if (n == 0) first_idx = rec.idx;
         index_q.push_back(rec);
         n++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (index_q.size() != 0) @(posedge clock);
      // a word landing on a full section still occupies the block briefly
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_palette_count(input logic [PALETTE_W-1:0] count);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we      <= 1'b0;
      palette_cfg = count;
   endtask

   initial begin
      int unsigned          n;
      logic [INDEX_W-1:0]   first;
      logic [PALETTE_W-1:0] cfg_v;
      logic [63:0]          word_v;
      logic                 start_v;

      palette_cfg = PALETTE_W'(16);
      sect_fill   = 0;

      //            set   count      word                   start typed n   first
      dir_rows[0]  = '{1'b0, 13'd0,    64'h0,                 1'b0, 1'b1, 5'd16, 12'h000};
      dir_rows[1]  = '{1'b0, 13'd0,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd16, 12'h00F};
      dir_rows[2]  = '{1'b0, 13'd0,    64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 5'd0,  12'h000};
      dir_rows[3]  = '{1'b1, 13'd0,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 5'd16, 12'h00F};
      dir_rows[4]  = '{1'b1, 13'd1,    64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 5'd16, 12'h000};
      dir_rows[5]  = '{1'b1, 13'd2,    64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 5'd0,  12'h000};
      dir_rows[6]  = '{1'b1, 13'd17,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd12, 12'h01F};
      dir_rows[7]  = '{1'b1, 13'd32,   64'h0,                 1'b1, 1'b1, 5'd12, 12'h000};
      dir_rows[8]  = '{1'b1, 13'd33,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd10, 12'h03F};
      dir_rows[9]  = '{1'b1, 13'd64,   64'h5555_5555_5555_5555, 1'b0, 1'b0, 5'd0,  12'h000};
      dir_rows[10] = '{1'b1, 13'd65,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd9,  12'h07F};
      dir_rows[11] = '{1'b1, 13'd129,  64'h0011_2233_4455_6677, 1'b0, 1'b1, 5'd8,  12'h077};
      dir_rows[12] = '{1'b1, 13'd257,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd7,  12'h1FF};
      dir_rows[13] = '{1'b1, 13'd513,  64'hDEAD_BEEF_0BAD_F00D, 1'b0, 1'b0, 5'd0,  12'h000};
      dir_rows[14] = '{1'b1, 13'd1025, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd5,  12'h7FF};
      dir_rows[15] = '{1'b1, 13'd2049, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd5,  12'hFFF};
      dir_rows[16] = '{1'b1, 13'd4096, 64'h8000_0000_0000_0001, 1'b1, 1'b1, 5'd5,  12'h001};
      dir_rows[17] = '{1'b1, 13'd4097, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 5'd5,  12'hFFF};
      dir_rows[18] = '{1'b1, 13'd8191, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 5'd0,  12'h000};
      dir_rows[19] = '{1'b1, 13'd16,   64'h8000_0000_0000_0000, 1'b1, 1'b1, 5'd16, 12'h000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].set_cfg) write_palette_count(dir_rows[i].cfg);
         offer_word(dir_rows[i].word, dir_rows[i].start, n, first);
         if (dir_rows[i].typed && n != dir_rows[i].n)
            report_mismatch($sformatf("row %0d index count", i), 64'(dir_rows[i].n), 64'(n));
         if (dir_rows[i].typed && first != dir_rows[i].first_idx)
            report_mismatch($sformatf("row %0d first index", i), 64'(dir_rows[i].first_idx),
                            64'(first));
      end

      // One whole section at 5 bits: it fills part way through a word,
      // and the trailing words land on a full section
      write_palette_count(PALETTE_W'(24));
      for (int i = 0; i < LONG_WORDS; i++) begin
         if (i == 200) drain_results();
         offer_word({$urandom, $urandom}, i == 0, n, first);
      end

      for (int p = 0; p < SHORT_PHASES; p++) begin
         if ($urandom_range(1, 0) != 0) begin
            case ($urandom_range(5, 0))
               0:       cfg_v = PALETTE_W'(0);
               1:       cfg_v = PALETTE_W'(1);
               2:       cfg_v = PALETTE_W'(16);
               3:       cfg_v = PALETTE_W'(17);
               4:       cfg_v = PALETTE_W'(4096);
               default: cfg_v = PALETTE_W'(8191);
            endcase
         end else begin
            cfg_v = PALETTE_W'($urandom_range(8191, 0));
         end
         write_palette_count(cfg_v);
         // hold the response side off so the block backs up into the request side
         if (p == 2) hold_id <= hold_id + 1;
         for (int i = 0; i < SHORT_WORDS; i++) begin
            case ($urandom_range(7, 0))
               0:       word_v = '0;
               1:       word_v = '1;
               default: word_v = {$urandom, $urandom};
            endcase
            start_v = (i == 0) ? ($urandom_range(3, 0) != 0) : ($urandom_range(5, 0) == 0);
            offer_word(word_v, start_v, n, first);
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
